// ===== rtl/integer_field_formatter_top_assert.svh =====
`ifndef INTEGER_FIELD_FORMATTER_TOP_ASSERT_SVH
`define INTEGER_FIELD_FORMATTER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge and disabled in reset.
`define IFMT_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge and disabled in reset.
`define IFMT_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ifmt_pkg.sv =====
package ifmt_pkg;

  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned MAX_FIELD_DEF  = 62;

  localparam int unsigned OP_W       = 3;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned FIELD_W    = 6;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned IN_USER_W  = OP_W;
  localparam int unsigned OUT_DATA_W = CHAR_W;

  localparam logic [OP_W-1:0] OP_SDEC = 3'd0;
  localparam logic [OP_W-1:0] OP_UDEC = 3'd1;
  localparam logic [OP_W-1:0] OP_HEXL = 3'd2;
  localparam logic [OP_W-1:0] OP_HEXU = 3'd3;
  localparam logic [OP_W-1:0] OP_PTR  = 3'd4;
  localparam logic [OP_W-1:0] OP_CHAR = 3'd5;
  localparam logic [OP_W-1:0] OP_PCT  = 3'd6;
  localparam logic [OP_W-1:0] OP_UNK  = 3'd7;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PCT   = 8'h25;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_X     = 8'h78;

  typedef struct packed {
    logic load;
    logic load_hex;
    logic dabble;
    logic shift;
  } dig_cmd_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
    logic [CHAR_W-1:0] res;
    if (d < 4'd10) begin
      res = CH_ZERO + {4'd0, d};
    end else begin
      res = (upper ? CH_UA : CH_LA) + {4'd0, d} - 8'd10;
    end
    return res;
  endfunction

endpackage

// ===== rtl/ifmt_digits.sv =====
module ifmt_digits #(
  parameter int unsigned VALUE_BITS = ifmt_pkg::VALUE_BITS_DEF,
  parameter int unsigned NDIG       = 10
) (
  input  logic                   clk_i,
  input  ifmt_pkg::dig_cmd_t     cmd_i,
  input  logic [VALUE_BITS-1:0]  value_i,
  output logic [3:0]             top_digit_o
);
  import ifmt_pkg::*;

  localparam int unsigned DIG_BITS = NDIG * 4;

  logic [DIG_BITS-1:0]   dig_q, dig_d, dab;
  logic [VALUE_BITS-1:0] val_q, val_d;

  // Each cycle of conversion adds three to every digit of five or more, then
  // shifts the next value bit in from the bottom.
  always_comb begin
    logic [3:0] d;
    d = '0;
    for (int i = 0; i < NDIG; i++) begin
      d = dig_q[i*4 +: 4];
      dab[i*4 +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
    end
  end

  always_comb begin
    dig_d = dig_q;
    val_d = val_q;
    priority if (cmd_i.load) begin
      dig_d = cmd_i.load_hex ? DIG_BITS'(value_i) : '0;
      val_d = value_i;
    end else if (cmd_i.dabble) begin
      dig_d = {dab[DIG_BITS-2:0], val_q[VALUE_BITS-1]};
      val_d = {val_q[VALUE_BITS-2:0], 1'b0};
    end else if (cmd_i.shift) begin
      dig_d = {dig_q[DIG_BITS-5:0], 4'd0};
    end else begin
      dig_d = dig_q;
      val_d = val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q <= dig_d;
    val_q <= val_d;
  end

  assign top_digit_o = dig_q[DIG_BITS-1 -: 4];

endmodule

// ===== rtl/integer_field_formatter_top.sv =====
// Formats one parsed integer conversion into ASCII characters, one character per
// output item, with tlast on the final character of the field. After an item is
// accepted, the decimal modes run a bit-serial binary-to-BCD conversion over all
// VALUE_BITS bits (hex and pointer skip it); leading zero digits are then
// stripped from the digit shift register for the integer and pointer modes, a
// planning step lays out the field, and the output phases follow in order:
// prefix, left padding, sign, zero padding, precision zeros, digits, right
// padding and byte. A character is emitted only while the output register is
// empty or being taken. The next item is accepted once the state machine is back
// in idle after the last character of the current one enters the output register,
// whether or not it has been taken.
module integer_field_formatter_top #(
  parameter int unsigned VALUE_BITS = ifmt_pkg::VALUE_BITS_DEF,
  parameter int unsigned MAX_FIELD  = ifmt_pkg::MAX_FIELD_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // value, field_width, prec_digits, precision_given, zero_flag, left_flag
  input  logic [ifmt_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // opcode
  input  logic [ifmt_pkg::IN_USER_W-1:0]  s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // ascii_char
  output logic [ifmt_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // last_char
  output logic                            m_axis_tlast_o
);
  import ifmt_pkg::*;

  localparam int unsigned NDEC  = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int unsigned NHEX  = (VALUE_BITS + 3) / 4;
  localparam int unsigned NDIG  = (NDEC > NHEX) ? NDEC : NHEX;
  localparam int unsigned MAXN  = (MAX_FIELD > NDIG) ? MAX_FIELD : NDIG;
  localparam int unsigned CNT_W = $clog2(MAXN + 3);
  localparam int unsigned LEN_W = $clog2(NDIG + 1);
  localparam int unsigned BC_W  = $clog2(VALUE_BITS + 1);
  localparam logic [FIELD_W-1:0] MAXF = FIELD_W'(MAX_FIELD);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CONV  = 4'd1;
  localparam logic [3:0] S_STRIP = 4'd2;
  localparam logic [3:0] S_PLAN  = 4'd3;
  localparam logic [3:0] S_PRE   = 4'd4;
  localparam logic [3:0] S_LPAD  = 4'd5;
  localparam logic [3:0] S_SIGN  = 4'd6;
  localparam logic [3:0] S_ZPAD  = 4'd7;
  localparam logic [3:0] S_PREC  = 4'd8;
  localparam logic [3:0] S_DIG   = 4'd9;
  localparam logic [3:0] S_RPAD  = 4'd10;
  localparam logic [3:0] S_BYTE  = 4'd11;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  logic [OP_W-1:0]    op_q, op_d;
  logic [FIELD_W-1:0] width_q, width_d, prec_q, prec_d;
  logic               pg_q, pg_d, zero_q, zero_d, left_q, left_d, neg_q, neg_d;
  logic [CHAR_W-1:0]  byte_q, byte_d;
  logic [BC_W-1:0]    bitcnt_q, bitcnt_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [1:0]         pre_q, pre_d;
  logic [CNT_W-1:0]   lpad_q, lpad_d, zpad_q, zpad_d, precz_q, precz_d, rpad_q, rpad_d;
  logic [CNT_W-1:0]   rem_q, rem_d;
  logic               byte_en_q, byte_en_d;
  logic [CHAR_W-1:0]  out_data_q, out_data_d;
  logic               out_last_q, out_last_d;

  logic [VALUE_W-1:0]    in_value;
  logic [FIELD_W-1:0]    in_fw, in_prec;
  logic [OP_W-1:0]       in_op;
  logic [VALUE_BITS-1:0] v_in, mag_in;
  logic                  neg_in;

  dig_cmd_t   cmd;
  logic [3:0] top_digit;

  logic             emit_ok, emit;
  logic [CHAR_W-1:0] emit_char;

  logic             p_int, p_ptr, p_zmode, p_byte;
  logic [1:0]       p_pre;
  logic [CNT_W-1:0] p_len, p_w, p_mind, p_precz, p_ndig, p_total, p_pad;

  assign in_value = s_axis_tdata_i[VALUE_W-1:0];
  assign in_fw    = s_axis_tdata_i[VALUE_W +: FIELD_W];
  assign in_prec  = s_axis_tdata_i[VALUE_W+FIELD_W +: FIELD_W];
  assign in_op    = s_axis_tuser_i;
  assign v_in     = VALUE_BITS'(in_value);
  assign neg_in   = (in_op == OP_SDEC) && v_in[VALUE_BITS-1];
  assign mag_in   = neg_in ? (~v_in + VALUE_BITS'(1)) : v_in;

  ifmt_digits #(
    .VALUE_BITS(VALUE_BITS),
    .NDIG      (NDIG)
  ) u_digits (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .value_i    (mag_in),
    .top_digit_o(top_digit)
  );

  // Field layout, worked out once the digit count is known.
  always_comb begin
    p_int   = (op_q <= OP_HEXU);
    p_ptr   = (op_q == OP_PTR);
    p_byte  = (op_q == OP_CHAR) || (op_q == OP_UNK);
    p_pre   = p_ptr ? 2'd2 : (((op_q == OP_PCT) || (op_q == OP_UNK)) ? 2'd1 : 2'd0);
    p_len   = CNT_W'(len_q);
    p_w     = CNT_W'(width_q);
    if (p_int) begin
      p_mind = pg_q ? CNT_W'(prec_q) : CNT_W'(1);
    end else begin
      p_mind = p_ptr ? CNT_W'(8) : '0;
    end
    p_precz = (p_mind > p_len) ? p_mind - p_len : '0;
    p_ndig  = p_len + p_precz;
    p_total = p_ndig + CNT_W'(neg_q);
    p_pad   = (p_int && (p_w > p_total)) ? p_w - p_total : '0;
    p_zmode = !pg_q && !left_q && zero_q;
  end

  assign emit_ok = !out_valid_q || m_axis_tready_i;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    width_d     = width_q;
    prec_d      = prec_q;
    pg_d        = pg_q;
    zero_d      = zero_q;
    left_d      = left_q;
    neg_d       = neg_q;
    byte_d      = byte_q;
    bitcnt_d    = bitcnt_q;
    len_d       = len_q;
    pre_d       = pre_q;
    lpad_d      = lpad_q;
    zpad_d      = zpad_q;
    precz_d     = precz_q;
    rpad_d      = rpad_q;
    rem_d       = rem_q;
    byte_en_d   = byte_en_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    cmd         = '0;
    emit        = 1'b0;
    emit_char   = CH_SPACE;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          op_d         = in_op;
          width_d      = (in_fw > MAXF) ? MAXF : in_fw;
          prec_d       = (in_prec > MAXF) ? MAXF : in_prec;
          pg_d         = s_axis_tdata_i[VALUE_W+2*FIELD_W];
          zero_d       = s_axis_tdata_i[VALUE_W+2*FIELD_W+1];
          left_d       = s_axis_tdata_i[VALUE_W+2*FIELD_W+2];
          neg_d        = neg_in;
          byte_d       = in_value[CHAR_W-1:0];
          cmd.load     = 1'b1;
          cmd.load_hex = (in_op == OP_HEXL) || (in_op == OP_HEXU) || (in_op == OP_PTR);
          bitcnt_d     = BC_W'(VALUE_BITS);
          if (in_op <= OP_UDEC) begin
            state_d = S_CONV;
            len_d   = LEN_W'(NDIG);
          end else if (in_op <= OP_PTR) begin
            state_d = S_STRIP;
            len_d   = LEN_W'(NDIG);
          end else begin
            state_d = S_PLAN;
            len_d   = '0;
          end
        end
      end
      S_CONV: begin
        cmd.dabble = 1'b1;
        bitcnt_d   = bitcnt_q - BC_W'(1);
        if (bitcnt_q == BC_W'(1)) begin
          state_d = S_STRIP;
        end
      end
      S_STRIP: begin
        if ((top_digit == 4'd0) && (len_q > LEN_W'(1))) begin
          cmd.shift = 1'b1;
          len_d     = len_q - LEN_W'(1);
        end else begin
          state_d = S_PLAN;
        end
      end
      S_PLAN: begin
        pre_d     = p_pre;
        lpad_d    = (!left_q && !p_zmode) ? p_pad : '0;
        zpad_d    = p_zmode ? p_pad : '0;
        rpad_d    = left_q ? p_pad : '0;
        precz_d   = p_precz;
        byte_en_d = p_byte;
        rem_d     = CNT_W'(p_pre) + p_pad + p_total + CNT_W'(p_byte);
        state_d   = S_PRE;
      end
      S_PRE: begin
        if (pre_q == 2'd0) begin
          state_d = S_LPAD;
        end else if (emit_ok) begin
          emit      = 1'b1;
          emit_char = p_ptr ? ((pre_q == 2'd2) ? CH_ZERO : CH_X) : CH_PCT;
          pre_d     = pre_q - 2'd1;
        end
      end
      S_LPAD: begin
        if (lpad_q == '0) begin
          state_d = S_SIGN;
        end else if (emit_ok) begin
          emit      = 1'b1;
          emit_char = CH_SPACE;
          lpad_d    = lpad_q - CNT_W'(1);
        end
      end
      S_SIGN: begin
        if (!neg_q) begin
          state_d = S_ZPAD;
        end else if (emit_ok) begin
          emit      = 1'b1;
          emit_char = CH_MINUS;
          neg_d     = 1'b0;
        end
      end
      S_ZPAD: begin
        if (zpad_q == '0) begin
          state_d = S_PREC;
        end else if (emit_ok) begin
          emit      = 1'b1;
          emit_char = CH_ZERO;
          zpad_d    = zpad_q - CNT_W'(1);
        end
      end
      S_PREC: begin
        if (precz_q == '0) begin
          state_d = S_DIG;
        end else if (emit_ok) begin
          emit      = 1'b1;
          emit_char = CH_ZERO;
          precz_d   = precz_q - CNT_W'(1);
        end
      end
      S_DIG: begin
        if (len_q == '0) begin
          state_d = S_RPAD;
        end else if (emit_ok) begin
          emit      = 1'b1;
          emit_char = digit_char(top_digit, op_q == OP_HEXU);
          cmd.shift = 1'b1;
          len_d     = len_q - LEN_W'(1);
        end
      end
      S_RPAD: begin
        if (rpad_q == '0) begin
          state_d = S_BYTE;
        end else if (emit_ok) begin
          emit      = 1'b1;
          emit_char = CH_SPACE;
          rpad_d    = rpad_q - CNT_W'(1);
        end
      end
      S_BYTE: begin
        if (!byte_en_q) begin
          state_d = S_IDLE;
        end else if (emit_ok) begin
          emit      = 1'b1;
          emit_char = byte_q;
          byte_en_d = 1'b0;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_d = 1'b1;
      out_data_d  = emit_char;
      out_last_d  = (rem_q == CNT_W'(1));
      rem_d       = rem_q - CNT_W'(1);
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    width_q    <= width_d;
    prec_q     <= prec_d;
    pg_q       <= pg_d;
    zero_q     <= zero_d;
    left_q     <= left_d;
    neg_q      <= neg_d;
    byte_q     <= byte_d;
    bitcnt_q   <= bitcnt_d;
    len_q      <= len_d;
    pre_q      <= pre_d;
    lpad_q     <= lpad_d;
    zpad_q     <= zpad_d;
    precz_q    <= precz_d;
    rpad_q     <= rpad_d;
    rem_q      <= rem_d;
    byte_en_q  <= byte_en_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ===== rtl/ifmt_checker.sv =====
`include "integer_field_formatter_top_assert.svh"

module ifmt_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic [ifmt_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  input logic [ifmt_pkg::IN_USER_W-1:0]  s_axis_tuser_i,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [ifmt_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic                            m_axis_tlast_o
);
  import ifmt_pkg::*;

  logic       s_fire, m_fire, end_fire;
  logic [1:0] open_q, open_d;

  assign s_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign m_fire   = m_axis_tvalid_o && m_axis_tready_i;
  assign end_fire = m_fire && m_axis_tlast_o;

  // An item is open from its acceptance until its last character is taken. The
  // last character of one item may still wait while the next item is accepted.
  always_comb begin
    open_d = open_q;
    unique case ({s_fire, end_fire})
      2'b10: begin
        open_d = open_q + 2'd1;
      end
      2'b01: begin
        open_d = open_q - 2'd1;
      end
      default: begin
        open_d = open_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 2'd0;
    end else begin
      open_q <= open_d;
    end
  end

  `IFMT_ASSERT_NXT(a_hold_after_accept, s_fire, !s_axis_tready_o, "input ready right after accept")
  `IFMT_ASSERT_IMP(a_no_stray_output, m_axis_tvalid_o, open_q != 2'd0, "output item without open input item")
  `IFMT_ASSERT_IMP(a_accept_only_at_end, s_fire, (open_q == 2'd0) || ((open_q == 2'd1) && m_axis_tvalid_o && m_axis_tlast_o), "new item accepted before previous field was complete")
  `IFMT_ASSERT_NXT(a_out_stall_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o), "stalled output item changed")

endmodule

bind integer_field_formatter_top ifmt_checker u_ifmt_checker (.*);
